/* src/tfd_pkg.sv */
// ============================================================================
// tfd_pkg - shared types and constants of the tagged frame deframer
// Result word layout, result kinds, delimiter bytes and default limits.
// ============================================================================
`default_nettype none

package tfd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;

    localparam int MAX_LABEL_DEF   = 32;
    localparam int MAX_PAYLOAD_DEF = 1024;

    // Result queue depth, must be a power of two and at least 2
    localparam int QDEPTH = 4;

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    localparam logic [KIND_W-1:0] K_LABEL      = 3'd0;
    localparam logic [KIND_W-1:0] K_PAYLOAD    = 3'd1;
    localparam logic [KIND_W-1:0] K_DONE       = 3'd2;
    localparam logic [KIND_W-1:0] K_ABORT_END  = 3'd3;
    localparam logic [KIND_W-1:0] K_ABORT_SIZE = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_result;

    // Up to two result words produced by one input word
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_core_out;

endpackage

`default_nettype wire

/* src/tagged_frame_deframer_unit.sv */
// ============================================================================
// tagged_frame_deframer_unit - byte-stream deframer for '/'-tagged frames
// Frames look like: '/' label ' ' payload ' ' label '/'. Label and payload
// bytes are released one per result word; the closing tag is dropped.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one received byte per word
//   plus an end-of-buffer flag. Output channel (o_out_valid / i_out_ready)
//   carries result words: byte, kind and a last-of-run flag that marks the
//   final result caused by one input byte. One input byte gives zero, one or
//   two result words.
//   Throughput: one input word per cycle, bounded by the output side at one
//   result word per cycle. The single-pass parser and tag compare sit between
//   the input register and a four-entry result queue.
//   Path: an accepted byte waits in the input register, is parsed from there
//   into the result queue, and its first result is shown from the queue head.
//   Stall: when the receiver holds i_out_ready low the queue fills; once fewer
//   than two slots are free the input register holds its byte and o_in_ready
//   drops after that register is occupied. Nothing is lost or reordered.
//   Reset (synchronous, active low): parser returns to seeking '/', queue and
//   input register empty. Label store and tag window are not cleared.
//   End of buffer: after the flagged byte, an open frame gives an
//   "aborted at buffer end" word and the parser restarts.
// ============================================================================
`default_nettype none

module tagged_frame_deframer_unit #(
    parameter int MAX_LABEL   = tfd_pkg::MAX_LABEL_DEF,
    parameter int MAX_PAYLOAD = tfd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [tfd_pkg::BYTE_W-1:0]  i_in_byte,
    input  wire logic                        i_end_of_buffer,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [tfd_pkg::BYTE_W-1:0]       o_out_byte,
    output logic [tfd_pkg::KIND_W-1:0]       o_out_kind,
    output logic                             o_last_of_run
);

    logic                        r_in_valid;
    logic [tfd_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_in_eob;
    logic                        space;
    logic                        proc;
    tfd_pkg::t_core_out          core_res;
    tfd_pkg::t_result            head;

    // Parse the held byte only when the queue has room for two words
    assign proc       = r_in_valid && space;
    assign o_in_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold payload until a new word is taken
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_eob  <= i_end_of_buffer;
        end
    end

    tfd_core #(
        .MAX_LABEL   (MAX_LABEL),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc),
        .i_byte  (r_in_byte),
        .i_eob   (r_in_eob),
        .o_res   (core_res)
    );

    tfd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (proc),
        .i_push_res (core_res),
        .o_space    (space),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (head)
    );

    assign o_out_byte    = head.data;
    assign o_out_kind    = head.kind;
    assign o_last_of_run = head.last;

endmodule

`default_nettype wire

/* src/tfd_core.sv */
// ============================================================================
// tfd_core - frame parser state and single-pass result logic
// Tracks phase, label store and tag window; computes up to two result words
// for the current input word and updates state when the word is consumed.
// ============================================================================
`default_nettype none

module tfd_core #(
    parameter int MAX_LABEL   = tfd_pkg::MAX_LABEL_DEF,
    parameter int MAX_PAYLOAD = tfd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [tfd_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                        i_eob,
    output tfd_pkg::t_core_out               o_res
);

    localparam int WIN    = MAX_LABEL + 2;
    localparam int LBL_W  = $clog2(MAX_LABEL + 1);
    localparam int FILL_W = $clog2(WIN);
    localparam int PCNT_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_LABEL   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    logic [1:0]                  r_phase, n_phase;
    logic [LBL_W-1:0]            r_len, n_len;
    logic [FILL_W-1:0]           r_fill, n_fill;
    logic [PCNT_W-1:0]           r_pcnt, n_pcnt;
    logic [tfd_pkg::BYTE_W-1:0]  r_label [MAX_LABEL];
    logic [tfd_pkg::BYTE_W-1:0]  n_label [MAX_LABEL];
    logic [tfd_pkg::BYTE_W-1:0]  r_win   [WIN];
    logic [tfd_pkg::BYTE_W-1:0]  n_win   [WIN];

    logic [tfd_pkg::BYTE_W-1:0]  win_in  [WIN];
    logic [tfd_pkg::BYTE_W-1:0]  tag     [WIN];
    logic                        match;
    logic                        full;
    logic                        prim_v;
    logic                        eob_v;
    tfd_pkg::t_result            prim;
    tfd_pkg::t_result            abort_res;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_fill  = r_fill;
        n_pcnt  = r_pcnt;
        n_label = r_label;
        n_win   = r_win;
        prim_v  = 1'b0;
        prim    = '0;
        eob_v   = 1'b0;

        // Window with the incoming byte placed at the fill position
        win_in = r_win;
        for (int k = 0; k < WIN; k++) begin
            if (r_fill == FILL_W'(k)) begin
                win_in[k] = i_byte;
            end
        end

        // Closing tag: space, label bytes, slash
        for (int k = 0; k < WIN; k++) begin
            tag[k] = tfd_pkg::CH_SLASH;
        end
        tag[0] = tfd_pkg::CH_SPACE;
        for (int k = 1; k <= MAX_LABEL; k++) begin
            tag[k] = r_label[k-1];
        end

        match = 1'b1;
        for (int k = 0; k < WIN; k++) begin
            if (k <= int'(r_len)) begin
                if (win_in[k] != tag[k]) begin
                    match = 1'b0;
                end
            end else if (k == int'(r_len) + 1) begin
                if (win_in[k] != tfd_pkg::CH_SLASH) begin
                    match = 1'b0;
                end
            end
        end

        full = (int'(r_fill) == int'(r_len) + 1);

        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == tfd_pkg::CH_SLASH) begin
                    n_phase = PH_LABEL;
                    n_len   = '0;
                end
            end
            PH_LABEL: begin
                if (i_byte == tfd_pkg::CH_SPACE) begin
                    n_phase = PH_PAYLOAD;
                    n_fill  = '0;
                    n_pcnt  = '0;
                end else if (int'(r_len) < MAX_LABEL) begin
                    for (int j = 0; j < MAX_LABEL; j++) begin
                        if (r_len == LBL_W'(j)) begin
                            n_label[j] = i_byte;
                        end
                    end
                    n_len  = r_len + 1'b1;
                    prim_v = 1'b1;
                    prim   = '{data: i_byte, kind: tfd_pkg::K_LABEL, last: 1'b0};
                end else begin
                    prim_v  = 1'b1;
                    prim    = '{data: '0, kind: tfd_pkg::K_ABORT_SIZE, last: 1'b0};
                    n_phase = PH_IDLE;
                    n_fill  = '0;
                    n_pcnt  = '0;
                end
            end
            PH_PAYLOAD: begin
                n_win = win_in;
                if (!full) begin
                    n_fill = r_fill + 1'b1;
                end else if (match) begin
                    prim_v  = 1'b1;
                    prim    = '{data: '0, kind: tfd_pkg::K_DONE, last: 1'b0};
                    n_phase = PH_IDLE;
                    n_fill  = '0;
                    n_pcnt  = '0;
                end else if (r_pcnt >= PCNT_W'(MAX_PAYLOAD)) begin
                    prim_v  = 1'b1;
                    prim    = '{data: '0, kind: tfd_pkg::K_ABORT_SIZE, last: 1'b0};
                    n_phase = PH_IDLE;
                    n_fill  = '0;
                    n_pcnt  = '0;
                end else begin
                    // release oldest byte, advance window; fill stays put
                    prim_v = 1'b1;
                    prim   = '{data: win_in[0], kind: tfd_pkg::K_PAYLOAD, last: 1'b0};
                    n_pcnt = r_pcnt + 1'b1;
                    for (int k = 0; k < WIN - 1; k++) begin
                        n_win[k] = win_in[k+1];
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_fill  = '0;
                n_pcnt  = '0;
            end
        endcase

        if (i_eob) begin
            eob_v   = (n_phase != PH_IDLE);
            n_phase = PH_IDLE;
            n_fill  = '0;
            n_pcnt  = '0;
        end
    end

    always_comb begin
        abort_res  = '{data: '0, kind: tfd_pkg::K_ABORT_END, last: 1'b1};
        o_res.cnt  = {1'b0, prim_v} + {1'b0, eob_v};
        o_res.res0 = prim_v ? prim : abort_res;
        o_res.res0.last = !(prim_v && eob_v);
        o_res.res1 = abort_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_fill  <= '0;
            r_pcnt  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_fill  <= n_fill;
            r_pcnt  <= n_pcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_label <= n_label;
            r_win   <= n_win;
        end
    end

endmodule

`default_nettype wire

/* src/tfd_outq.sv */
// ============================================================================
// tfd_outq - result word queue
// Takes up to two result words per cycle, releases one per output handshake.
// ============================================================================
`default_nettype none

module tfd_outq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire tfd_pkg::t_core_out  i_push_res,
    output logic                     o_space,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output tfd_pkg::t_result         o_res
);

    localparam int DEPTH = tfd_pkg::QDEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfd_pkg::t_result   r_q [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [1:0]         push_n;
    logic               pop;

    assign o_space = (r_cnt <= CNT_W'(DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_q[r_rd];
    assign pop     = o_valid && i_ready;
    assign push_n  = i_push ? i_push_res.cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr] <= i_push_res.res0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr + 1'b1] <= i_push_res.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(push_n);
            r_rd  <= r_rd + PTR_W'(pop);
            r_cnt <= r_cnt + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench - self-checking bench for tagged_frame_deframer_unit
// Drives byte words with end-of-buffer flags through a bursty sender, keeps a
// bit-accurate deframer model that predicts each result word, and checks the
// output channel word by word under a randomly stalling receiver.
// ============================================================================

module testbench;

    localparam int BYTE_W       = tfd_pkg::BYTE_W;
    localparam int KIND_W       = tfd_pkg::KIND_W;
    localparam int LABEL_MAX    = tfd_pkg::MAX_LABEL_DEF;
    localparam int PAYLOAD_MAX  = tfd_pkg::MAX_PAYLOAD_DEF;
    localparam int WIN_LEN      = LABEL_MAX + 2;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_WORDS = 250;

    typedef enum logic [1:0] {SEEK_SLASH, IN_LABEL, IN_PAYLOAD} t_parse_phase;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [BYTE_W-1:0]   i_in_byte = '0;
    logic                i_end_of_buffer = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [BYTE_W-1:0]   o_out_byte;
    logic [KIND_W-1:0]   o_out_kind;
    logic                o_last_of_run;

    tagged_frame_deframer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_out_kind      (o_out_kind),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Deframer model state
    t_parse_phase      ph = SEEK_SLASH;
    logic [BYTE_W-1:0] lbl [LABEL_MAX];
    int                lbl_len = 0;
    logic [BYTE_W-1:0] win [WIN_LEN];
    int                win_fill = 0;
    int                pay_count = 0;
    int                worked_words = 0;

    tfd_pkg::t_result  expected_words[$];
    tfd_pkg::t_result  oldest;
    int                errors = 0;

    // Sender and receiver pacing
    int                burst_left = 0;
    int                gap_max = 0;
    bit                hold_req = 1'b0;
    int                hold_left = 0;
    int                stall_pct = 0;
    int                pattern_left = 0;
    int                quiet = 0;

    logic [BYTE_W-1:0] frame_bytes[$];
    logic [BYTE_W-1:0] rnd_label [LABEL_MAX + 1];
    int                rnd_label_len;

    function automatic tfd_pkg::t_result make_word(input logic [BYTE_W-1:0] d,
                                                   input logic [KIND_W-1:0] k);
        tfd_pkg::t_result w;
        w.data = d;
        w.kind = k;
        w.last = 1'b0;
        return w;
    endfunction

    function automatic logic [BYTE_W-1:0] closing_tag_byte(input int k);
        if (k == 0) return tfd_pkg::CH_SPACE;
        if (k <= lbl_len) return lbl[k-1];
        return tfd_pkg::CH_SLASH;
    endfunction

    // Append one byte to the frame being built
    task automatic add_byte(input logic [BYTE_W-1:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endtask

    // Work out the result words of one accepted input word
    task automatic predict_words(input logic [BYTE_W-1:0] b, input logic eob);
        tfd_pkg::t_result run[$];
        int               tag_len;
        logic             hit;
        if (ph != SEEK_SLASH || b == tfd_pkg::CH_SLASH) worked_words++;
        case (ph)
            SEEK_SLASH: begin
                if (b == tfd_pkg::CH_SLASH) begin
                    ph = IN_LABEL;
                    lbl_len = 0;
                end
            end
            IN_LABEL: begin
                if (b == tfd_pkg::CH_SPACE) begin
                    ph = IN_PAYLOAD;
                    win_fill = 0;
                    pay_count = 0;
                end else if (lbl_len < LABEL_MAX) begin
                    lbl[lbl_len] = b;
                    lbl_len++;
                    run.insert(run.size(), make_word(b, tfd_pkg::K_LABEL));
                end else begin
                    run.insert(run.size(), make_word('0, tfd_pkg::K_ABORT_SIZE));
                    ph = SEEK_SLASH;
                end
            end
            default: begin
                tag_len = lbl_len + 2;
                if (win_fill < WIN_LEN) begin
                    win[win_fill] = b;
                    win_fill++;
                end
                if (win_fill >= tag_len) begin
                    hit = 1'b1;
                    for (int k = 0; k < tag_len; k++)
                        if (win[k] != closing_tag_byte(k)) hit = 1'b0;
                    if (hit) begin
                        run.insert(run.size(), make_word('0, tfd_pkg::K_DONE));
                        ph = SEEK_SLASH;
                    end else if (pay_count >= PAYLOAD_MAX) begin
                        run.insert(run.size(), make_word('0, tfd_pkg::K_ABORT_SIZE));
                        ph = SEEK_SLASH;
                    end else begin
                        run.insert(run.size(), make_word(win[0], tfd_pkg::K_PAYLOAD));
                        pay_count++;
                        for (int k = 0; k < WIN_LEN - 1; k++) win[k] = win[k+1];
                        win_fill--;
                    end
                end
            end
        endcase
        if (eob) begin
            if (ph != SEEK_SLASH)
                run.insert(run.size(), make_word('0, tfd_pkg::K_ABORT_END));
            ph = SEEK_SLASH;
        end
        if (run.size() > 0) run[run.size()-1].last = 1'b1;
        foreach (run[i]) expected_words.insert(expected_words.size(), run[i]);
    endtask

    // Offer one word; gaps open between bursts of random length
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic eob);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (!o_in_ready);
        predict_words(b, eob);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // Send the collected bytes; flag buffer end on the last one or at random
    task automatic flush_frame(input bit eob_last, input bit stray_eob);
        logic eob;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            eob = (eob_last && i == frame_bytes.size() - 1) ||
                  (stray_eob && $urandom_range(0, 199) < 3);
            send_word(frame_bytes[i], eob);
        end
        frame_bytes.delete();
    endtask

    function automatic logic [BYTE_W-1:0] pick_letter();
        return BYTE_W'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Check each result word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word byte %02h kind %0d last %b",
                         $time, o_out_byte, o_out_kind, o_last_of_run);
                errors++;
            end else begin
                oldest = expected_words.pop_front();
                if (o_out_byte !== oldest.data) begin
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, oldest.data, o_out_byte);
                    errors++;
                end
                if (o_out_kind !== oldest.kind) begin
                    $display("%0t: out_kind expected %0d got %0d",
                             $time, oldest.kind, o_out_kind);
                    errors++;
                end
                if (o_last_of_run !== oldest.last) begin
                    $display("%0t: last_of_run expected %b got %b",
                             $time, oldest.last, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    // Receiver: stall rate is redrawn at random when its pattern runs out; a hold
    // request blocks it entirely for a long stretch
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                pattern_left = $urandom_range(20, 200);
            end else begin
                pattern_left--;
            end
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Stray bytes, tiny frames, label with slash, empty label, extreme
    // payload bytes, buffer end on label, payload and closing bytes
    task automatic test_directed();
        gap_max = 3;
        add_byte(8'h00);
        add_byte(8'hFF);
        flush_frame(1'b0, 1'b0);
        add_text("/a/ ");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text(" a//");
        flush_frame(1'b1, 1'b0);
        add_text("/ z /");
        flush_frame(1'b0, 1'b0);
        add_text("/q");
        flush_frame(1'b1, 1'b0);
        add_text("/b x");
        flush_frame(1'b1, 1'b0);
    endtask

    // Full-size label closes a frame; one byte more aborts
    task automatic test_label_limits();
        logic [BYTE_W-1:0] name [LABEL_MAX + 1];
        gap_max = 2;
        foreach (name[i]) name[i] = pick_letter();
        add_byte(tfd_pkg::CH_SLASH);
        for (int i = 0; i < LABEL_MAX; i++) add_byte(name[i]);
        add_text(" hi ");
        for (int i = 0; i < LABEL_MAX; i++) add_byte(name[i]);
        add_byte(tfd_pkg::CH_SLASH);
        add_byte(tfd_pkg::CH_SLASH);
        for (int i = 0; i < LABEL_MAX + 1; i++) add_byte(name[i]);
        flush_frame(1'b1, 1'b0);
    endtask

    // Release the payload up to the limit, then abort on the next byte
    task automatic test_payload_limits();
        gap_max = 0;
        add_text("/p ");
        repeat (PAYLOAD_MAX + 6) add_byte(pick_letter());
        flush_frame(1'b1, 1'b0);
    endtask

    // Hold the receiver off while the sender streams without gaps
    task automatic test_backpressure();
        gap_max = 0;
        hold_req = 1'b1;
        add_text("/tag ");
        repeat (60) add_byte(BYTE_W'($urandom_range(0, 255)));
        add_text(" tag/");
        flush_frame(1'b0, 1'b0);
    endtask

    task automatic build_random_frame();
        int                r;
        int                pay_len;
        int                cut;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 85) rnd_label_len = $urandom_range(0, 6);
        else if (r < 95) rnd_label_len = $urandom_range(7, 31);
        else rnd_label_len = $urandom_range(32, 33);
        for (int i = 0; i < rnd_label_len; i++) begin
            b = ($urandom_range(0, 1) == 0) ? BYTE_W'($urandom_range(8'h61, 8'h63))
                                            : BYTE_W'($urandom_range(0, 255));
            rnd_label[i] = (b == tfd_pkg::CH_SPACE) ? 8'h5F : b;
        end
        pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
                                              : $urandom_range(0, 16);
        add_byte(tfd_pkg::CH_SLASH);
        for (int i = 0; i < rnd_label_len; i++) add_byte(rnd_label[i]);
        add_byte(tfd_pkg::CH_SPACE);
        for (int i = 0; i < pay_len; i++) begin
            r = $urandom_range(0, 9);
            if (r < 2) b = tfd_pkg::CH_SPACE;
            else if (r == 2) b = tfd_pkg::CH_SLASH;
            else if (r < 5 && rnd_label_len > 0)
                b = rnd_label[$urandom_range(0, rnd_label_len - 1)];
            else b = BYTE_W'($urandom_range(0, 255));
            add_byte(b);
        end
        add_byte(tfd_pkg::CH_SPACE);
        for (int i = 0; i < rnd_label_len; i++) add_byte(rnd_label[i]);
        add_byte(tfd_pkg::CH_SLASH);
        // Break some frames: cut the closing tag short or corrupt one byte
        r = $urandom_range(0, 99);
        if (r < 8) begin
            cut = $urandom_range(1, 3);
            repeat (cut) void'(frame_bytes.pop_back());
        end else if (r < 15) begin
            cut = $urandom_range(1, rnd_label_len + 2);
            frame_bytes[frame_bytes.size() - cut] = BYTE_W'($urandom_range(0, 255));
        end
    endtask

    task automatic test_random_frames();
        int base;
        int frames;
        base = worked_words;
        frames = 0;
        while (worked_words - base < RANDOM_WORDS) begin
            if (frames % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 10;
                endcase
            end
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 10)) add_byte(BYTE_W'($urandom_range(0, 255)));
            end else begin
                build_random_frame();
            end
            flush_frame($urandom_range(0, 99) < 30, 1'b1);
            frames++;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_label_limits();
        test_payload_limits();
        test_backpressure();
        test_random_frames();
        i_in_valid <= 1'b0;
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
